// ----- sv/tws_pkg.sv -----
// Shared types and constants for the time window sum block.
// Depends on nothing; every other file of the block imports it.
package tws_pkg;

   localparam int VALUE_W = 32;
   localparam int TIME_W  = 48;
   localparam int SUM_W   = 40;
   localparam int COUNT_W = 9;
   localparam int WLEN_W  = 32;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 32'd1000000;

   // One stored sample.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [TIME_W-1:0]         stamp;
      logic                      good;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

endpackage

// ----- sv/tws_if.sv -----
// Valid/ready channel interfaces for requests and responses of the block.
// Depends on tws_pkg for the field widths.
interface tws_req_if
   import tws_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sample_value;
   logic [TIME_W-1:0]         sample_time;
   logic                      sample_valid;
   logic                      reset_request;

   modport source (output valid, sample_value, sample_time, sample_valid, reset_request,
                   input ready);
   modport sink   (input valid, sample_value, sample_time, sample_valid, reset_request,
                   output ready);
endinterface

interface tws_rsp_if
   import tws_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   window_sum;
   logic [COUNT_W-1:0]        invalid_count;
   logic [COUNT_W-1:0]        total_count;
   logic                      was_reset;
   logic                      no_valid_data;
   logic                      overflow_evicted;

   modport source (output valid, window_sum, invalid_count, total_count, was_reset,
                   no_valid_data, overflow_evicted, input ready);
   modport sink   (input valid, window_sum, invalid_count, total_count, was_reset,
                   no_valid_data, overflow_evicted, output ready);
endinterface

// ----- sv/tws_store.sv -----
// Sample store: one synchronous memory, one write and one read port,
// read data registered. Depends on tws_pkg for the entry type.
module tws_store
   import tws_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/time_window_sum_core.sv -----
// Top level of the sliding time window sum: control sequencer, counters,
// running sum and response register. Depends on tws_pkg, tws_if, tws_store.
//
//   channel   direction  handshake        contents
//   req_if    in         valid/ready      sample value, time, valid flag, reset request
//   rsp_if    out        valid/ready      window sum, counts and status flags
//   csr_*     in         write enable     window length in ticks
//
// A reset request is handled in the idle state. Any other request moves to
// the check state, where each expired sample popped needs a fresh read of
// the oldest entry through the single registered read port of the store.
// Reset is synchronous; it clears the control state and counters and loads
// the default window length. The sample store itself is never cleared, only
// occupied entries are read. A new request is taken only when the response
// register is empty or is being emptied in the same cycle, so a stalled
// response holds the block.

module time_window_sum_core
   import tws_pkg::*;
#(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   tws_req_if.sink           req_if,
   tws_rsp_if.source         rsp_if,
   input  logic              csr_write_enable,
   input  logic [WLEN_W-1:0] csr_write_data
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   // Advance a ring index, wrapping at the last entry.
   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
      logic [AW-1:0] r;
      if (s == AW'(WINDOW_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // Sign extension of a sample value to the width of the running sum.
   function automatic logic [SUM_W-1:0] widen(input logic signed [VALUE_W-1:0] v);
      return {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
   endfunction

   // Counts are reported modulo the width of the response fields.
   function automatic logic [COUNT_W-1:0] report(input logic [CW-1:0] c);
      logic [CW+COUNT_W-1:0] e;
      e = {{COUNT_W{1'b0}}, c};
      return e[COUNT_W-1:0];
   endfunction

   // Control and window state.
   state_type         state_ff, state_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [AW-1:0]     newest_ff, newest_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     bad_ff, bad_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic              first_ff, first_in;
   logic [WLEN_W-1:0] wlen_ff;

   // The request being worked on.
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic                      good_ff, good_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]          rsp_sum_ff, rsp_sum_in;
   logic [COUNT_W-1:0]        rsp_bad_ff, rsp_bad_in;
   logic [COUNT_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic                      rsp_reset_ff, rsp_reset_in;
   logic                      rsp_none_ff, rsp_none_in;
   logic                      rsp_evict_ff, rsp_evict_in;

   // Store ports.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic              accept;
   logic              rsp_free;
   logic              backward;
   logic              expired;
   logic              evict;
   logic [TIME_W-1:0] age;
   logic [SUM_W-1:0]  drop_total;
   logic [CW-1:0]     drop_bad;
   logic [SUM_W-1:0]  base_total;
   logic [CW-1:0]     base_fill;
   logic [CW-1:0]     base_bad;
   logic [AW-1:0]     base_oldest;
   logic [AW-1:0]     push_slot;

   tws_store #(
      .DEPTH (WINDOW_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_if.valid && req_if.ready;

   // Expiry and ordering tests against the oldest entry just read.
   assign age        = time_ff - rd_data.stamp;
   assign backward   = (time_ff <= rd_data.stamp);
   assign expired    = !backward && (age > {{(TIME_W - WLEN_W){1'b0}}, wlen_ff});
   assign evict      = (fill_ff == CW'(WINDOW_DEPTH));

   // Effect of removing the oldest entry.
   assign drop_total = total_ff - widen(rd_data.value);
   assign drop_bad   = (!rd_data.good && (bad_ff != '0)) ? bad_ff - 1'b1 : bad_ff;

   // Window state seen by the push, after an eviction if the window is full.
   assign base_total  = evict ? drop_total : total_ff;
   assign base_bad    = evict ? drop_bad : bad_ff;
   assign base_fill   = evict ? fill_ff - 1'b1 : fill_ff;
   assign base_oldest = evict ? next_slot(oldest_ff) : oldest_ff;
   assign push_slot   = (base_fill == '0) ? base_oldest : next_slot(newest_ff);

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      fill_in      = fill_ff;
      bad_in       = bad_ff;
      total_in     = total_ff;
      first_in     = first_ff;
      val_in       = val_ff;
      time_in      = time_ff;
      good_in      = good_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_reset_in = rsp_reset_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_evict_in = rsp_evict_ff;
      wr_en        = 1'b0;
      wr_addr      = push_slot;
      wr_data      = '{value: val_ff, stamp: time_ff, good: good_ff};
      rd_addr      = oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in   = req_if.sample_value;
               time_in  = req_if.sample_time;
               good_in  = req_if.sample_valid;
               first_in = 1'b1;
               if (req_if.reset_request) begin
                  // An explicit reset request clears the window at once.
                  oldest_in    = '0;
                  newest_in    = '0;
                  fill_in      = '0;
                  bad_in       = '0;
                  total_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = '0;
                  rsp_bad_in   = '0;
                  rsp_fill_in  = '0;
                  rsp_reset_in = 1'b1;
                  rsp_none_in  = 1'b1;
                  rsp_evict_in = 1'b0;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            first_in = 1'b0;
            if (fill_ff != '0 && first_ff && backward) begin
               // The new time is not later than the oldest stored sample.
               oldest_in    = '0;
               newest_in    = '0;
               fill_in      = '0;
               bad_in       = '0;
               total_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_sum_in   = '0;
               rsp_bad_in   = '0;
               rsp_fill_in  = '0;
               rsp_reset_in = 1'b1;
               rsp_none_in  = 1'b1;
               rsp_evict_in = 1'b0;
               state_in     = ST_IDLE;
            end else if (fill_ff != '0 && expired) begin
               // Pop one expired sample and fetch the next oldest.
               total_in  = drop_total;
               bad_in    = drop_bad;
               fill_in   = fill_ff - 1'b1;
               oldest_in = next_slot(oldest_ff);
               rd_addr   = next_slot(oldest_ff);
            end else begin
               // Evict if still full, then push the new sample and report.
               // The store write lands before the next request reads it.
               wr_en        = 1'b1;
               oldest_in    = base_oldest;
               newest_in    = push_slot;
               fill_in      = base_fill + 1'b1;
               bad_in       = base_bad + CW'(!good_ff);
               total_in     = base_total + widen(val_ff);
               rsp_valid_in = 1'b1;
               rsp_sum_in   = total_in;
               rsp_bad_in   = report(bad_in);
               rsp_fill_in  = report(fill_in);
               rsp_reset_in = 1'b0;
               rsp_none_in  = (bad_in >= fill_in);
               rsp_evict_in = evict;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         fill_ff      <= '0;
         bad_ff       <= '0;
         total_ff     <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         bad_ff       <= bad_in;
         total_ff     <= total_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Window length register; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_RESET;
      end else if (csr_write_enable) begin
         wlen_ff <= csr_write_data;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      time_ff      <= time_in;
      good_ff      <= good_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_reset_ff <= rsp_reset_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.window_sum       = rsp_sum_ff;
   assign rsp_if.invalid_count    = rsp_bad_ff;
   assign rsp_if.total_count      = rsp_fill_ff;
   assign rsp_if.was_reset        = rsp_reset_ff;
   assign rsp_if.no_valid_data    = rsp_none_ff;
   assign rsp_if.overflow_evicted = rsp_evict_ff;

endmodule

// ----- tb/sv/tws_window_checker.sv -----
// Response checker for the time window sum block: keeps its own copy of the
// sample window, predicts every response and compares it field by field.
// Depends on tws_pkg for widths and the entry type, and on tws_if.
module tws_window_checker
   import tws_pkg::*;
#(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   tws_req_if                req_bus,
   tws_rsp_if                rsp_bus,
   input  logic              csr_write_enable,
   input  logic [WLEN_W-1:0] csr_write_data,
   output int unsigned       failure_count,
   output int unsigned       responses_owed
);

   typedef struct packed {
      logic signed [SUM_W-1:0] window_sum;
      logic [COUNT_W-1:0]      invalid_count;
      logic [COUNT_W-1:0]      total_count;
      logic                    was_reset;
      logic                    no_valid_data;
      logic                    overflow_evicted;
   } window_report_type;

   entry_type               held [WINDOW_DEPTH];
   int unsigned             head_slot;
   int unsigned             tail_slot;
   int unsigned             held_count;
   int unsigned             bad_count;
   logic signed [SUM_W-1:0] running_sum;
   logic [WLEN_W-1:0]       window_ticks;
   entry_type               arriving;
   window_report_type       expected_reports [$];

   function automatic logic signed [SUM_W-1:0] widen(logic signed [VALUE_W-1:0] v);
      return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
   endfunction

   function automatic void clear_window();
      head_slot   = 0;
      tail_slot   = 0;
      held_count  = 0;
      bad_count   = 0;
      running_sum = '0;
   endfunction

   // Removes the oldest sample and takes it out of the sum and the counts.
   function automatic void drop_oldest();
      running_sum = running_sum - widen(held[head_slot].value);
      if (!held[head_slot].good && bad_count > 0) begin
         bad_count--;
      end
      held_count--;
      head_slot = (head_slot + 1) % WINDOW_DEPTH;
   endfunction

   // Applies one request to the window and returns the response it causes.
   function automatic window_report_type advance_window(entry_type sample, logic clear_req);
      window_report_type report;
      report = '0;
      if (clear_req || (held_count > 0 && sample.stamp <= held[head_slot].stamp)) begin
         clear_window();
         report.was_reset     = 1'b1;
         report.no_valid_data = 1'b1;
         return report;
      end
      while (held_count > 0 && held[head_slot].stamp < sample.stamp &&
             (sample.stamp - held[head_slot].stamp) > {16'd0, window_ticks}) begin
         drop_oldest();
      end
      if (held_count >= WINDOW_DEPTH) begin
         drop_oldest();
         report.overflow_evicted = 1'b1;
      end
      if (held_count == 0) begin
         tail_slot = head_slot;
      end else begin
         tail_slot = (tail_slot + 1) % WINDOW_DEPTH;
      end
      held[tail_slot] = sample;
      held_count++;
      if (!sample.good) begin
         bad_count++;
      end
      running_sum = running_sum + widen(sample.value);
      report.window_sum    = running_sum;
      report.invalid_count = COUNT_W'(bad_count);
      report.total_count   = COUNT_W'(held_count);
      report.no_valid_data = (bad_count >= held_count);
      return report;
   endfunction

   function automatic void note_failure(string text);
      failure_count++;
      if (failure_count <= 10) begin
         $display("%0t: %s", $time, text);
      end
   endfunction

   function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         note_failure($sformatf("%s mismatch: expected %h, got %h", field, want, got));
      end
   endfunction

   function automatic void check_report();
      window_report_type want;
      if (expected_reports.size() == 0) begin
         note_failure($sformatf("response with no request outstanding: sum %h total %0d",
                                rsp_bus.window_sum, rsp_bus.total_count));
         return;
      end
      want = expected_reports.pop_front();
      compare_field("window_sum", want.window_sum, rsp_bus.window_sum);
      compare_field("invalid_count", want.invalid_count, rsp_bus.invalid_count);
      compare_field("total_count", want.total_count, rsp_bus.total_count);
      compare_field("was_reset", want.was_reset, rsp_bus.was_reset);
      compare_field("no_valid_data", want.no_valid_data, rsp_bus.no_valid_data);
      compare_field("overflow_evicted", want.overflow_evicted, rsp_bus.overflow_evicted);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_window();
         window_ticks = WLEN_RESET;
         expected_reports.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_report();
         end
         if (csr_write_enable) begin
            window_ticks = csr_write_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            arriving.value = req_bus.sample_value;
            arriving.stamp = req_bus.sample_time;
            arriving.good  = req_bus.sample_valid;
            expected_reports.push_back(advance_window(arriving, req_bus.reset_request));
         end
      end
      responses_owed = expected_reports.size();
   end

endmodule

// ----- tb/sv/time_window_sum_core_tb.sv -----
// Top of the time window sum testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on tws_pkg, tws_if,
// time_window_sum_core and tws_window_checker.
module time_window_sum_core_tb
   import tws_pkg::*;
   ();

   localparam int DEPTH        = 256;
   // Longest legal quiet stretch is the long response hold-off
   // or a full window of pops plus both idle gaps; this limit is several times that.
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 190;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [WLEN_W-1:0] csr_write_data;
   int unsigned       failure_count;
   int unsigned       responses_owed;
   int unsigned       quiet_cycles;
   bit                send_rush;
   logic [WLEN_W-1:0] window_now;

   tws_req_if req_bus ();
   tws_rsp_if rsp_bus ();

   time_window_sum_core #(
      .WINDOW_DEPTH (DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   tws_window_checker #(
      .WINDOW_DEPTH (DEPTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failure_count    (failure_count),
      .responses_owed   (responses_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request and returns at the falling edge after it was taken.
   // Must be called at a falling edge. The valid line is left high so that a
   // back-to-back request follows without a bubble; the caller lowers it
   // before any pause. Now and then the sender switches between random idle
   // gaps and a stretch with no gaps at all.
   task automatic offer_sample(input logic signed [VALUE_W-1:0] value,
                               input logic [TIME_W-1:0] stamp,
                               input logic good, input logic clear);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) begin
         send_rush = !send_rush;
      end
      gap = send_rush ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample_value  <= value;
      req_bus.sample_time   <= stamp;
      req_bus.sample_valid  <= good;
      req_bus.reset_request <= clear;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Lowers the request valid and waits until every response has come back,
   // so that the block is idle.
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (responses_owed != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the window length while the block is idle.
   task automatic set_window(input logic [WLEN_W-1:0] ticks);
      drain_requests();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      window_now        = ticks;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random part of one window setting. The stimulus is built from runs: a
   // run starts at a random timestamp (often after an explicit reset request)
   // and then climbs. Most steps stay inside the window so that the FIFO
   // holds several samples and expiry pops a few at a time; some steps jump
   // past the window to pop everything, a few go backwards or are plain
   // noise. About one run in twelve is longer than the FIFO with steps small
   // enough that nothing expires at the longer window lengths, which forces
   // evictions and drives the sum to its extremes when the values are constant.
   task automatic fill_phase(input int unsigned goal);
      logic [TIME_W-1:0]         stamp;
      logic signed [VALUE_W-1:0] value;
      logic                      good;
      longint unsigned           span;
      int unsigned               run_len;
      int unsigned               value_mode;
      int unsigned               good_mode;
      int unsigned               roll;
      int unsigned               placed;
      bit                        dense;
      placed = 0;
      while (placed < goal) begin
         run_len    = ($urandom_range(0, 11) == 0) ? $urandom_range(258, 300)
                                                   : $urandom_range(1, 40);
         dense      = (run_len > DEPTH) || ($urandom_range(0, 2) == 0);
         value_mode = $urandom_range(0, 5);
         good_mode  = $urandom_range(0, 3);
         span       = dense ? (longint'(window_now) / 512) : (longint'(window_now) / 3);
         if (span < 2) begin
            span = 2;
         end
         stamp = {16'($urandom), 32'($urandom)};
         if ($urandom_range(0, 1) == 1) begin
            offer_sample($urandom, {16'($urandom), 32'($urandom)}, 1'($urandom), 1'b1);
            placed++;
         end
         for (int unsigned i = 0; i < run_len; i++) begin
            case (value_mode)
               3: value = 32'sh7FFF_FFFF;
               4: value = 32'sh8000_0000;
               5: begin
                  case ($urandom_range(0, 3))
                     0: value = 32'sh7FFF_FFFF;
                     1: value = 32'sh8000_0000;
                     2: value = 32'sh0000_0000;
                     default: value = 32'shFFFF_FFFF;
                  endcase
               end
               default: value = $urandom;
            endcase
            case (good_mode)
               0: good = 1'b0;
               1: good = 1'b1;
               default: good = 1'($urandom);
            endcase
            roll = (run_len > DEPTH) ? 39 : $urandom_range(0, 39);
            if (roll == 0) begin
               // A reset request in the middle of a run, with random content.
               offer_sample(value, {16'($urandom), 32'($urandom)}, good, 1'b1);
            end else begin
               if (roll == 1) begin
                  stamp = stamp - $urandom_range(0, 40);
               end else if (roll < 4) begin
                  stamp = TIME_W'(stamp + longint'(window_now) + 1 +
                                  $urandom_range(0, 1000));
               end else if (roll == 4) begin
                  stamp = {16'($urandom), 32'($urandom)};
               end else begin
                  stamp = stamp + $urandom_range(0, 32'(span));
               end
               offer_sample(value, stamp, good, 1'b0);
            end
            placed++;
         end
      end
   endtask

   // Response side. Each response waits a random number of cycles with ready
   // low, with stretches of no waiting at all. Twice in the run the receiver
   // holds off for a long time while the sender keeps offering requests, so
   // the response register fills and the block stalls its request input.
   initial begin : response_taker
      int unsigned gap;
      int unsigned taken;
      bit          rush;
      taken = 0;
      rush  = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rush = !rush;
         end
         gap = rush ? 0 : $urandom_range(0, 12);
         if (taken == 200 || taken == 1100) begin
            gap = 400;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) begin
            @(posedge clock);
         end
         taken++;
         @(negedge clock);
      end
   end

   // Ends the run when neither channel moves a request or a response for
   // too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      send_rush             = 1'b0;
      window_now            = WLEN_RESET;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.sample_value  = '0;
      req_bus.sample_time   = '0;
      req_bus.sample_valid  = 1'b0;
      req_bus.reset_request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, at the reset window length of one million ticks.
      // The first sample lands in an empty window at time zero; equal times
      // with a later oldest sample are kept, a time equal to the oldest one
      // clears the window.
      offer_sample(32'sh7FFF_FFFF, 48'd0, 1'b1, 1'b0);
      offer_sample(32'sh8000_0000, 48'd100, 1'b0, 1'b0);
      offer_sample(32'shFFFF_FFFF, 48'd100, 1'b0, 1'b0);
      offer_sample(32'sh0000_0005, 48'd0, 1'b1, 1'b0);
      // Reset request with every other field at its maximum.
      offer_sample(32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
      // Expiry boundary: a gap of exactly the window length keeps the old
      // sample, one tick more pops it.
      offer_sample(32'sh0001_0000, 48'd5, 1'b1, 1'b0);
      offer_sample(32'sh0002_0000, 48'd1000005, 1'b1, 1'b0);
      offer_sample(32'sh0003_0000, 48'd1000006, 1'b0, 1'b0);
      // The largest timestamp pops everything, then repeating it is a
      // backward step.
      offer_sample(32'sh1234_5678, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      offer_sample(32'sh0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      // Only invalid samples: the no-valid-data flag with a non-empty window,
      // then cleared by one valid sample.
      offer_sample(32'sh8000_0000, 48'h8000_0000_0000, 1'b0, 1'b0);
      offer_sample(32'sh8000_0000, 48'h8000_0000_0001, 1'b0, 1'b0);
      offer_sample(32'sh7FFF_FFFF, 48'h8000_0000_0002, 1'b1, 1'b0);
      offer_sample(32'sh0000_0000, 48'd1, 1'b1, 1'b0);
      offer_sample(32'sh0000_0000, 48'd0, 1'b0, 1'b1);

      // Random part over several window lengths, the extremes among them.
      // A zero length pops every strictly earlier sample.
      set_window(32'd0);
      fill_phase(PHASE_ITEMS);
      set_window(32'd1);
      fill_phase(PHASE_ITEMS);
      set_window(32'd37);
      fill_phase(PHASE_ITEMS);
      set_window(32'hFFFF_FFFF);
      fill_phase(PHASE_ITEMS);
      set_window(32'd1000000);
      fill_phase(PHASE_ITEMS);
      set_window(32'hA5A5_5A5A);
      fill_phase(PHASE_ITEMS);

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && responses_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tws_pkg.sv
sv/tws_if.sv
sv/tws_store.sv
sv/time_window_sum_core.sv
tb/sv/tws_window_checker.sv
tb/sv/time_window_sum_core_tb.sv
